### rtl/clle_pkg.sv
// ----------------------------------------------------------------------------
// clle_pkg
// Shared types and codes of the linked list engine: command codes, status
// codes, controller states and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package clle_pkg;

   localparam int NODE_COUNT_DEF = 16;
   localparam int CNT_W          = 5;

   localparam logic [3:0] OP_CLEAR      = 4'd0;
   localparam logic [3:0] OP_MODIFY     = 4'd1;
   localparam logic [3:0] OP_VIEW       = 4'd2;
   localparam logic [3:0] OP_INS_FIRST  = 4'd3;
   localparam logic [3:0] OP_INS_LAST   = 4'd4;
   localparam logic [3:0] OP_INS_AFTER  = 4'd5;
   localparam logic [3:0] OP_DEL_FIRST  = 4'd6;
   localparam logic [3:0] OP_DEL_LAST   = 4'd7;
   localparam logic [3:0] OP_DEL_KEY    = 4'd8;
   localparam logic [3:0] OP_FREE_COUNT = 4'd9;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_EMPTY     = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_NO_MEM    = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_FIND,
      S_VIEW,
      S_ALLOC,
      S_TAIL,
      S_LINK,
      S_UNLINK,
      S_RELEASE,
      S_COUNT,
      S_EMIT
   } state_type;

   typedef enum logic [3:0] {
      A_NOP,
      A_LATCH,
      A_CLEAR,
      A_SEEK_HEAD,
      A_SEEK_FREE,
      A_STEP,
      A_VIEW,
      A_FILL,
      A_FETCH_FREE,
      A_ALLOC_HEAD,
      A_ALLOC_TAIL,
      A_ALLOC_AFTER,
      A_LINK_CUR,
      A_UNLINK,
      A_RELEASE
   } act_type;

   typedef struct packed {
      act_type    act;
      logic       emit;
      logic       res_load;
      logic [1:0] res_status;
      logic       res_data;
      logic       res_count;
   } cmd_type;

   typedef struct packed {
      logic [3:0] op;
      logic       empty;
      logic       cur_node;
      logic       next_node;
      logic       steps_left;
      logic       key_hit;
      logic       free_avail;
      logic       view_last;
      logic       no_count;
      logic       out_free;
   } stat_type;

endpackage

`default_nettype wire

### rtl/clle_datapath.sv
// ----------------------------------------------------------------------------
// clle_datapath
// Node store (keys, payloads, links), list and free heads, walk registers,
// result holding register and the output register of the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module clle_datapath #(
   parameter int NODE_COUNT = clle_pkg::NODE_COUNT_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  clle_pkg::cmd_type        cmd,
   output clle_pkg::stat_type       stat,
   input  logic [3:0]               req_operation,
   input  logic signed [31:0]       req_match_key,
   input  logic signed [31:0]       req_new_key,
   input  logic [31:0]              req_new_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [1:0]               rsp_status,
   output logic signed [31:0]       rsp_key_out,
   output logic [31:0]              rsp_payload_out,
   output logic [clle_pkg::CNT_W-1:0] rsp_count_out,
   output logic                     rsp_last
);
   import clle_pkg::*;

   localparam int IW = $clog2(NODE_COUNT);
   localparam int LW = $clog2(NODE_COUNT + 1);
   localparam logic [LW-1:0] NIL = LW'(NODE_COUNT);

   // node store
   logic [LW-1:0]        link_mem [NODE_COUNT];
   logic signed [31:0]   key_mem  [NODE_COUNT];
   logic [31:0]          pay_mem  [NODE_COUNT];

   logic [3:0]           op_ff, op_in;
   logic signed [31:0]   mkey_ff, mkey_in, nkey_ff, nkey_in;
   logic [31:0]          npay_ff, npay_in;
   logic [LW-1:0]        head_ff, head_in, free_ff, free_in;
   logic [LW-1:0]        cur_ff, cur_in, prev_ff, prev_in;
   logic [LW-1:0]        new_ff, new_in, nxt_ff, nxt_in;
   logic [LW-1:0]        steps_ff, steps_in;
   logic [NODE_COUNT-1:0] valid_ff, valid_in;
   logic [LW-1:0]        rd_addr_ff, rd_addr_in;
   logic                 rd_valid_ff, rd_valid_in;
   logic [LW-1:0]        rd_link_ff;
   logic signed [31:0]   rd_key_ff;
   logic [31:0]          rd_pay_ff;
   logic [1:0]           res_status_ff, res_status_in;
   logic signed [31:0]   res_key_ff, res_key_in;
   logic [31:0]          res_pay_ff, res_pay_in;
   logic [CNT_W-1:0]     res_cnt_ff, res_cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic signed [31:0]   rsp_key_ff, rsp_key_in;
   logic [31:0]          rsp_pay_ff, rsp_pay_in;
   logic [CNT_W-1:0]     rsp_cnt_ff, rsp_cnt_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 rd_en;
   logic [LW-1:0]        rd_addr;
   logic                 lk_we;
   logic [LW-1:0]        lk_addr, lk_data;
   logic                 kp_we;
   logic [LW-1:0]        kp_addr;
   logic                 valid_clr;
   logic [LW-1:0]        rd_link;
   logic [LW-1:0]        steps_inc;
   logic                 view_last;
   logic                 out_free;

   function automatic logic node_ok(input logic [LW-1:0] x);
      return x < NIL;
   endfunction

   // a link never written reads as its chain value, i + 1
   assign rd_link   = rd_valid_ff ? rd_link_ff : rd_addr_ff + LW'(1);
   assign steps_inc = steps_ff + LW'(1);
   assign view_last = !node_ok(rd_link) || (steps_inc >= NIL);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      stat.op         = op_ff;
      stat.empty      = !node_ok(head_ff);
      stat.cur_node   = node_ok(cur_ff);
      stat.next_node  = node_ok(rd_link);
      stat.steps_left = steps_ff < NIL;
      stat.key_hit    = rd_key_ff == mkey_ff;
      stat.free_avail = node_ok(free_ff);
      stat.view_last  = view_last;
      stat.no_count   = steps_ff == '0;
      stat.out_free   = out_free;
   end

   always_comb begin
      op_in     = op_ff;
      mkey_in   = mkey_ff;
      nkey_in   = nkey_ff;
      npay_in   = npay_ff;
      head_in   = head_ff;
      free_in   = free_ff;
      cur_in    = cur_ff;
      prev_in   = prev_ff;
      new_in    = new_ff;
      nxt_in    = nxt_ff;
      steps_in  = steps_ff;
      rd_en     = 1'b0;
      rd_addr   = cur_ff;
      lk_we     = 1'b0;
      lk_addr   = cur_ff;
      lk_data   = NIL;
      kp_we     = 1'b0;
      kp_addr   = cur_ff;
      valid_clr = 1'b0;
      unique case (cmd.act)
         A_NOP: begin
         end
         A_LATCH: begin
            op_in   = req_operation;
            mkey_in = req_match_key;
            nkey_in = req_new_key;
            npay_in = req_new_payload;
         end
         A_CLEAR: begin
            head_in   = NIL;
            free_in   = '0;
            valid_clr = 1'b1;
         end
         A_SEEK_HEAD: begin
            cur_in   = head_ff;
            prev_in  = NIL;
            steps_in = '0;
            rd_en    = 1'b1;
            rd_addr  = head_ff;
         end
         A_SEEK_FREE: begin
            cur_in   = free_ff;
            prev_in  = NIL;
            steps_in = '0;
            rd_en    = 1'b1;
            rd_addr  = free_ff;
         end
         A_STEP, A_VIEW: begin
            prev_in  = cur_ff;
            cur_in   = rd_link;
            steps_in = steps_inc;
            rd_en    = 1'b1;
            rd_addr  = rd_link;
         end
         A_FILL: begin
            kp_we   = 1'b1;
            kp_addr = cur_ff;
         end
         A_FETCH_FREE: begin
            new_in  = free_ff;
            nxt_in  = rd_link;
            rd_en   = 1'b1;
            rd_addr = free_ff;
         end
         A_ALLOC_HEAD: begin
            free_in = rd_link;
            kp_we   = 1'b1;
            kp_addr = new_ff;
            lk_we   = 1'b1;
            lk_addr = new_ff;
            lk_data = node_ok(head_ff) ? head_ff : NIL;
            head_in = new_ff;
         end
         A_ALLOC_TAIL: begin
            free_in  = rd_link;
            kp_we    = 1'b1;
            kp_addr  = new_ff;
            lk_we    = 1'b1;
            lk_addr  = new_ff;
            lk_data  = NIL;
            // start the walk to the tail in the same cycle
            cur_in   = head_ff;
            prev_in  = NIL;
            steps_in = '0;
            rd_en    = 1'b1;
            rd_addr  = head_ff;
         end
         A_ALLOC_AFTER: begin
            free_in = rd_link;
            kp_we   = 1'b1;
            kp_addr = new_ff;
            lk_we   = 1'b1;
            lk_addr = new_ff;
            lk_data = nxt_ff;
         end
         A_LINK_CUR: begin
            lk_we   = 1'b1;
            lk_addr = cur_ff;
            lk_data = new_ff;
         end
         A_UNLINK: begin
            if (node_ok(prev_ff)) begin
               lk_we   = 1'b1;
               lk_addr = prev_ff;
               lk_data = rd_link;
            end else begin
               head_in = rd_link;
            end
         end
         A_RELEASE: begin
            lk_we   = 1'b1;
            lk_addr = cur_ff;
            lk_data = free_ff;
            free_in = cur_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (valid_clr) begin
         valid_in = '0;
      end else if (lk_we) begin
         valid_in[lk_addr[IW-1:0]] = 1'b1;
      end
      rd_addr_in  = rd_en ? rd_addr : rd_addr_ff;
      rd_valid_in = rd_en ? valid_ff[rd_addr[IW-1:0]] : rd_valid_ff;
   end

   always_comb begin
      res_status_in = res_status_ff;
      res_key_in    = res_key_ff;
      res_pay_in    = res_pay_ff;
      res_cnt_in    = res_cnt_ff;
      if (cmd.res_load) begin
         res_status_in = cmd.res_status;
         res_key_in    = cmd.res_data ? rd_key_ff : '0;
         res_pay_in    = cmd.res_data ? rd_pay_ff : '0;
         res_cnt_in    = cmd.res_count ? CNT_W'(steps_ff) : '0;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_pay_in    = rsp_pay_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      rsp_last_in   = rsp_last_ff;
      if (cmd.emit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_key_in    = res_key_ff;
         rsp_pay_in    = res_pay_ff;
         rsp_cnt_in    = res_cnt_ff;
         rsp_last_in   = 1'b1;
      end else if (cmd.act == A_VIEW) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = ST_OK;
         rsp_key_in    = rd_key_ff;
         rsp_pay_in    = rd_pay_ff;
         rsp_cnt_in    = CNT_W'(steps_inc);
         rsp_last_in   = view_last;
      end
   end

   always_ff @(posedge clock) begin
      if (lk_we) begin
         link_mem[lk_addr[IW-1:0]] <= lk_data;
      end
      if (kp_we) begin
         key_mem[kp_addr[IW-1:0]] <= nkey_ff;
         pay_mem[kp_addr[IW-1:0]] <= npay_ff;
      end
      if (rd_en) begin
         rd_link_ff <= link_mem[rd_addr[IW-1:0]];
         rd_key_ff  <= key_mem[rd_addr[IW-1:0]];
         rd_pay_ff  <= pay_mem[rd_addr[IW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= NIL;
         free_ff      <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         free_ff      <= free_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      mkey_ff       <= mkey_in;
      nkey_ff       <= nkey_in;
      npay_ff       <= npay_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      new_ff        <= new_in;
      nxt_ff        <= nxt_in;
      steps_ff      <= steps_in;
      rd_addr_ff    <= rd_addr_in;
      rd_valid_ff   <= rd_valid_in;
      res_status_ff <= res_status_in;
      res_key_ff    <= res_key_in;
      res_pay_ff    <= res_pay_in;
      res_cnt_ff    <= res_cnt_in;
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_pay_ff    <= rsp_pay_in;
      rsp_cnt_ff    <= rsp_cnt_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_key_out     = rsp_key_ff;
   assign rsp_payload_out = rsp_pay_ff;
   assign rsp_count_out   = rsp_cnt_ff;
   assign rsp_last        = rsp_last_ff;

   a_emit_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit || cmd.act == A_VIEW) |-> (!rsp_valid_ff || rsp_ready))
      else $error("result beat loaded over an untaken beat");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.act == A_CLEAR |=> (head_ff == NIL && free_ff == '0 && valid_ff == '0))
      else $error("clear did not rebuild the free chain");

   a_link_range: assert property (@(posedge clock) disable iff (reset)
      lk_we |-> lk_addr < NIL)
      else $error("link write outside the node store");

   a_node_range: assert property (@(posedge clock) disable iff (reset)
      kp_we |-> kp_addr < NIL)
      else $error("node write outside the node store");

endmodule

`default_nettype wire

### rtl/clle_ctrl.sv
// ----------------------------------------------------------------------------
// clle_ctrl
// Command sequencer of the linked list engine: decodes the command, runs
// the list and free chain walks, and orders the store updates.
// ----------------------------------------------------------------------------
`default_nettype none

module clle_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  clle_pkg::stat_type  stat,
   output clle_pkg::cmd_type   cmd
);
   import clle_pkg::*;

   state_type state_ff, state_in;
   logic      alive;
   logic      more_tail;

   assign alive     = stat.cur_node && stat.steps_left;
   assign more_tail = stat.next_node && stat.steps_left;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            priority case (stat.op)
               OP_CLEAR: state_in = S_EMIT;
               OP_MODIFY, OP_INS_AFTER, OP_DEL_KEY:
                  state_in = stat.empty ? S_EMIT : S_FIND;
               OP_VIEW: state_in = stat.empty ? S_EMIT : S_VIEW;
               OP_INS_FIRST, OP_INS_LAST:
                  state_in = stat.free_avail ? S_ALLOC : S_EMIT;
               OP_DEL_FIRST: state_in = stat.empty ? S_EMIT : S_UNLINK;
               OP_DEL_LAST: state_in = stat.empty ? S_EMIT : S_TAIL;
               OP_FREE_COUNT: state_in = S_COUNT;
               default: state_in = S_IDLE;
            endcase
         end
         S_FIND: begin
            if (!alive) begin
               state_in = S_EMIT;
            end else if (stat.key_hit) begin
               priority case (stat.op)
                  OP_MODIFY: state_in = S_EMIT;
                  OP_INS_AFTER: state_in = stat.free_avail ? S_ALLOC : S_EMIT;
                  default: state_in = S_RELEASE;
               endcase
            end
         end
         S_VIEW: begin
            if (stat.out_free && stat.view_last) state_in = S_IDLE;
         end
         S_ALLOC: begin
            priority case (stat.op)
               OP_INS_FIRST: state_in = S_EMIT;
               OP_INS_LAST: state_in = stat.empty ? S_EMIT : S_TAIL;
               default: state_in = S_LINK;
            endcase
         end
         S_TAIL: begin
            if (!more_tail) state_in = (stat.op == OP_INS_LAST) ? S_EMIT : S_RELEASE;
         end
         S_LINK:    state_in = S_EMIT;
         S_UNLINK:  state_in = S_RELEASE;
         S_RELEASE: state_in = S_EMIT;
         S_COUNT: begin
            if (!alive) state_in = S_EMIT;
         end
         S_EMIT: begin
            if (stat.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ready      = 1'b0;
      cmd.act        = A_NOP;
      cmd.emit       = 1'b0;
      cmd.res_load   = 1'b0;
      cmd.res_status = ST_OK;
      cmd.res_data   = 1'b0;
      cmd.res_count  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.act = A_LATCH;
         end
         S_DECODE: begin
            priority case (stat.op)
               OP_CLEAR: begin
                  cmd.act      = A_CLEAR;
                  cmd.res_load = 1'b1;
               end
               OP_MODIFY, OP_INS_AFTER, OP_DEL_KEY, OP_VIEW, OP_DEL_FIRST,
               OP_DEL_LAST: begin
                  if (stat.empty) begin
                     cmd.res_load   = 1'b1;
                     cmd.res_status = ST_EMPTY;
                  end else begin
                     cmd.act = A_SEEK_HEAD;
                  end
               end
               OP_INS_FIRST, OP_INS_LAST: begin
                  if (stat.free_avail) begin
                     cmd.act = A_FETCH_FREE;
                  end else begin
                     cmd.res_load   = 1'b1;
                     cmd.res_status = ST_NO_MEM;
                  end
               end
               OP_FREE_COUNT: cmd.act = A_SEEK_FREE;
               default: begin
               end
            endcase
         end
         S_FIND: begin
            if (!alive) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = ST_NOT_FOUND;
            end else if (stat.key_hit) begin
               priority case (stat.op)
                  OP_MODIFY: begin
                     cmd.act      = A_FILL;
                     cmd.res_load = 1'b1;
                  end
                  OP_INS_AFTER: begin
                     if (stat.free_avail) begin
                        cmd.act = A_FETCH_FREE;
                     end else begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = ST_NO_MEM;
                     end
                  end
                  default: begin
                     cmd.act      = A_UNLINK;
                     cmd.res_load = 1'b1;
                     cmd.res_data = 1'b1;
                  end
               endcase
            end else begin
               cmd.act = A_STEP;
            end
         end
         S_VIEW: begin
            if (stat.out_free) cmd.act = A_VIEW;
         end
         S_ALLOC: begin
            priority case (stat.op)
               OP_INS_FIRST: begin
                  cmd.act      = A_ALLOC_HEAD;
                  cmd.res_load = 1'b1;
               end
               OP_INS_LAST: begin
                  cmd.act      = stat.empty ? A_ALLOC_HEAD : A_ALLOC_TAIL;
                  cmd.res_load = 1'b1;
               end
               default: cmd.act = A_ALLOC_AFTER;
            endcase
         end
         S_TAIL: begin
            if (more_tail) begin
               cmd.act = A_STEP;
            end else if (stat.op == OP_INS_LAST) begin
               cmd.act      = A_LINK_CUR;
               cmd.res_load = 1'b1;
            end else begin
               cmd.act      = A_UNLINK;
               cmd.res_load = 1'b1;
               cmd.res_data = 1'b1;
            end
         end
         S_LINK: begin
            cmd.act      = A_LINK_CUR;
            cmd.res_load = 1'b1;
         end
         S_UNLINK: begin
            cmd.act      = A_UNLINK;
            cmd.res_load = 1'b1;
            cmd.res_data = 1'b1;
         end
         S_RELEASE: cmd.act = A_RELEASE;
         S_COUNT: begin
            if (alive) begin
               cmd.act = A_STEP;
            end else begin
               cmd.res_load   = 1'b1;
               cmd.res_status = stat.no_count ? ST_NO_MEM : ST_OK;
               cmd.res_count  = 1'b1;
            end
         end
         S_EMIT: begin
            if (stat.out_free) cmd.emit = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### rtl/cursor_linked_list_engine.sv
// ----------------------------------------------------------------------------
// cursor_linked_list_engine
// Singly linked list with a free chain over a fixed node store, one command
// per request beat; a known command gets one or more response beats.
// ----------------------------------------------------------------------------
// One command is in work at a time; a request beat is taken whenever the
// sequencer is idle, even while the previous response beat still waits.
// Each command is captured and decoded, then follows one link at a time
// (searches, the walk to the tail, the free count), up to NODE_COUNT links,
// and ends with its store updates; view sends one beat per node per cycle
// when the response side keeps up. The node store has a single read port
// with a registered output, and the link of each node reads as its free
// chain value until first written, so reset and clear need not write the
// store.
`default_nettype none

module cursor_linked_list_engine #(
   parameter int NODE_COUNT = clle_pkg::NODE_COUNT_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [3:0]                 req_operation,
   input  logic signed [31:0]         req_match_key,
   input  logic signed [31:0]         req_new_key,
   input  logic [31:0]                req_new_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [1:0]                 rsp_status,
   output logic signed [31:0]         rsp_key_out,
   output logic [31:0]                rsp_payload_out,
   output logic [clle_pkg::CNT_W-1:0] rsp_count_out,
   output logic                       rsp_last
);
   import clle_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   clle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   clle_datapath #(
      .NODE_COUNT (NODE_COUNT)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_operation   (req_operation),
      .req_match_key   (req_match_key),
      .req_new_key     (req_new_key),
      .req_new_payload (req_new_payload),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_key_out     (rsp_key_out),
      .rsp_payload_out (rsp_payload_out),
      .rsp_count_out   (rsp_count_out),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire

### tb/sv/cursor_linked_list_engine_tb.sv
// ----------------------------------------------------------------------------
// cursor_linked_list_engine_tb
// Drives list commands through the request channel, predicts every response
// beat with a behavioral model of the node store and free chain, and checks
// the response channel beat by beat under random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cursor_linked_list_engine_tb;
   import clle_pkg::*;

   localparam int NODES      = 16;
   localparam int NIL        = NODES;
   localparam int IDLE_LIMIT = 20000;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] key;
      logic [31:0] payload;
      logic [4:0]  count;
      logic        last;
   } beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [3:0] req_operation = '0;
   logic signed [31:0] req_match_key = '0;
   logic signed [31:0] req_new_key = '0;
   logic [31:0] req_new_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_status;
   logic signed [31:0] rsp_key_out;
   logic [31:0] rsp_payload_out;
   logic [4:0] rsp_count_out;
   logic rsp_last;

   cursor_linked_list_engine i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_operation(req_operation), .req_match_key(req_match_key),
      .req_new_key(req_new_key), .req_new_payload(req_new_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp_status), .rsp_key_out(rsp_key_out),
      .rsp_payload_out(rsp_payload_out), .rsp_count_out(rsp_count_out),
      .rsp_last(rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // list model
   logic [31:0] key_mem [NODES];
   logic [31:0] pay_mem [NODES];
   int          link_mem [NODES];
   int          list_top;
   int          free_top;
   beat_type    expected_beats [$];
   int          errors = 0;
   int          idle_cycles = 0;
   int          rsp_idle_left = 0;
   bit          rsp_hold = 1'b0;
   bit          idle_enable = 1'b1;
   logic [31:0] used_keys [$];

   function automatic void rebuild_chain();
      for (int i = 0; i < NODES; i++) link_mem[i] = i + 1;
      list_top = NIL;
      free_top = 0;
   endfunction

   function automatic void push_beat(logic [1:0] st, logic [31:0] k, logic [31:0] p,
                                     int c, bit fin);
      beat_type b;
      b.status = st; b.key = k; b.payload = p; b.count = c[4:0]; b.last = fin;
      expected_beats.push_back(b);
   endfunction

   function automatic int search_key(logic [31:0] k, output int prev);
      int cur, p, steps;
      cur = list_top; p = NIL; steps = 0;
      prev = NIL;
      while (cur < NODES && steps < NODES) begin
         if (key_mem[cur] == k) begin
            prev = p;
            return cur;
         end
         p = cur; cur = link_mem[cur]; steps++;
      end
      return NIL;
   endfunction

   function automatic int grab_node();
      int n;
      n = free_top;
      if (n >= NODES) return NIL;
      free_top = link_mem[n];
      link_mem[n] = NIL;
      return n;
   endfunction

   function automatic void predict_list_cmd(logic [3:0] op, logic [31:0] mk,
                                            logic [31:0] nk, logic [31:0] np);
      int n, cur, prev, cnt, k;
      bit empty;
      empty = (list_top >= NODES);
      if (op == OP_CLEAR) begin
         rebuild_chain();
         push_beat(ST_OK, 0, 0, 0, 1);
         return;
      end
      if (op > OP_FREE_COUNT) return;
      if (empty && op inside {OP_MODIFY, OP_VIEW, OP_INS_AFTER, OP_DEL_FIRST,
                              OP_DEL_LAST, OP_DEL_KEY}) begin
         push_beat(ST_EMPTY, 0, 0, 0, 1);
         return;
      end
      case (op)
         OP_MODIFY: begin
            cur = search_key(mk, prev);
            if (cur >= NODES) push_beat(ST_NOT_FOUND, 0, 0, 0, 1);
            else begin
               key_mem[cur] = nk; pay_mem[cur] = np;
               push_beat(ST_OK, 0, 0, 0, 1);
            end
         end
         OP_VIEW: begin
            cur = list_top; k = 0;
            while (cur < NODES && k < NODES) begin
               n = link_mem[cur];
               push_beat(ST_OK, key_mem[cur], pay_mem[cur], k + 1,
                         n >= NODES || k + 1 >= NODES);
               k++; cur = n;
            end
         end
         OP_INS_FIRST, OP_INS_LAST: begin
            n = grab_node();
            if (n >= NODES) push_beat(ST_NO_MEM, 0, 0, 0, 1);
            else begin
               key_mem[n] = nk; pay_mem[n] = np;
               if (op == OP_INS_FIRST || empty) begin
                  link_mem[n] = empty ? NIL : list_top;
                  list_top = n;
               end else begin
                  cur = list_top; cnt = 0;
                  while (link_mem[cur] < NODES && cnt < NODES) begin
                     cur = link_mem[cur]; cnt++;
                  end
                  link_mem[cur] = n;
               end
               push_beat(ST_OK, 0, 0, 0, 1);
            end
         end
         OP_INS_AFTER: begin
            cur = search_key(mk, prev);
            if (cur >= NODES) push_beat(ST_NOT_FOUND, 0, 0, 0, 1);
            else begin
               n = grab_node();
               if (n >= NODES) push_beat(ST_NO_MEM, 0, 0, 0, 1);
               else begin
                  key_mem[n] = nk; pay_mem[n] = np;
                  link_mem[n] = link_mem[cur];
                  link_mem[cur] = n;
                  push_beat(ST_OK, 0, 0, 0, 1);
               end
            end
         end
         OP_DEL_FIRST, OP_DEL_LAST, OP_DEL_KEY: begin
            cur = list_top; prev = NIL;
            if (op == OP_DEL_LAST) begin
               cnt = 0;
               while (link_mem[cur] < NODES && cnt < NODES) begin
                  prev = cur; cur = link_mem[cur]; cnt++;
               end
            end else if (op == OP_DEL_KEY) begin
               cur = search_key(mk, prev);
            end
            if (cur >= NODES) push_beat(ST_NOT_FOUND, 0, 0, 0, 1);
            else begin
               if (prev < NODES) link_mem[prev] = link_mem[cur];
               else list_top = link_mem[cur];
               push_beat(ST_OK, key_mem[cur], pay_mem[cur], 0, 1);
               link_mem[cur] = free_top;
               free_top = cur;
            end
         end
         default: begin
            cnt = 0; cur = free_top;
            while (cur < NODES && cnt < NODES) begin
               cnt++; cur = link_mem[cur];
            end
            push_beat(cnt == 0 ? ST_NO_MEM : ST_OK, 0, 0, cnt, 1);
         end
      endcase
   endfunction

   task automatic send_cmd(logic [3:0] op, logic [31:0] mk, logic [31:0] nk,
                           logic [31:0] np);
      if (idle_enable && $urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 5)) @(negedge clock);
      req_valid <= 1'b1;
      req_operation <= op;
      req_match_key <= mk;
      req_new_key <= nk;
      req_new_payload <= np;
      do @(posedge clock); while (!req_ready);
      predict_list_cmd(op, mk, nk, np);
      if (nk != 0) used_keys.push_back(nk);
      @(negedge clock);
      req_valid <= 1'b0;
      // the engine is still decoding here, so the gap costs no throughput
      @(negedge clock);
   endtask

   task automatic wait_drained();
      while (expected_beats.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   function automatic logic [31:0] pick_key();
      if (used_keys.size() != 0 && $urandom_range(0, 3) != 0)
         return used_keys[$urandom_range(0, used_keys.size() - 1)];
      return $urandom_range(0, 3) == 0 ? $urandom_range(0, 7) : $urandom;
   endfunction

   // response receiver: random bursts of backpressure, long hold on request
   always @(negedge clock) begin
      if (reset || rsp_hold) begin
         rsp_ready <= 1'b0;
      end else if (rsp_idle_left > 0) begin
         rsp_ready     <= 1'b0;
         rsp_idle_left <= rsp_idle_left - 1;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
         rsp_ready     <= 1'b0;
         rsp_idle_left <= $urandom_range(0, 4);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         beat_type e;
         if (expected_beats.size() == 0) begin
            $error("unexpected response beat status=%0d", rsp_status);
            errors++;
         end else begin
            e = expected_beats.pop_front();
            if (rsp_status !== e.status) begin
               $error("status: expected %0d actual %0d", e.status, rsp_status); errors++;
            end
            if (rsp_key_out !== e.key) begin
               $error("key_out: expected %0h actual %0h", e.key, rsp_key_out); errors++;
            end
            if (rsp_payload_out !== e.payload) begin
               $error("payload_out: expected %0h actual %0h", e.payload, rsp_payload_out);
               errors++;
            end
            if (rsp_count_out !== e.count) begin
               $error("count_out: expected %0d actual %0d", e.count, rsp_count_out); errors++;
            end
            if (rsp_last !== e.last) begin
               $error("last: expected %0d actual %0d", e.last, rsp_last); errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         idle_cycles <= 0;
      else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   task automatic test_directed();
      send_cmd(OP_VIEW, 0, 0, 0);
      send_cmd(OP_MODIFY, 0, 0, 0);
      send_cmd(OP_INS_AFTER, 0, 1, 1);
      send_cmd(OP_DEL_FIRST, 0, 0, 0);
      send_cmd(OP_DEL_LAST, 0, 0, 0);
      send_cmd(OP_DEL_KEY, 0, 0, 0);
      send_cmd(OP_FREE_COUNT, 0, 0, 0);
      send_cmd(OP_INS_LAST, 0, 32'h8000_0000, 32'hffff_ffff);
      send_cmd(OP_INS_FIRST, 0, 32'h7fff_ffff, 32'h0);
      send_cmd(OP_INS_AFTER, 32'h8000_0000, -1, 32'h5555_aaaa);
      send_cmd(OP_INS_AFTER, 32'h1234, 5, 5);
      send_cmd(OP_MODIFY, 32'h7fff_ffff, 32'h7fff_ffff, 32'haaaa_5555);
      send_cmd(OP_MODIFY, 32'h4444, 1, 1);
      send_cmd(OP_VIEW, 0, 0, 0);
      send_cmd(OP_DEL_KEY, -1, 0, 0);
      send_cmd(OP_DEL_KEY, 99, 0, 0);
      send_cmd(OP_DEL_LAST, 0, 0, 0);
      send_cmd(OP_DEL_FIRST, 0, 0, 0);
      send_cmd(4'd10, 0, 0, 0);
      send_cmd(4'd15, -1, -1, -1);
      send_cmd(OP_CLEAR, 0, 0, 0);
   endtask

   // fill the store, overflow it, then drain it
   task automatic test_full_store();
      for (int i = 0; i < NODES; i++) send_cmd(OP_INS_LAST, 0, i, $urandom);
      send_cmd(OP_FREE_COUNT, 0, 0, 0);
      send_cmd(OP_INS_FIRST, 0, 1, 1);
      send_cmd(OP_INS_LAST, 0, 1, 1);
      send_cmd(OP_INS_AFTER, 3, 1, 1);
      send_cmd(OP_INS_AFTER, 1000, 1, 1);
      send_cmd(OP_VIEW, 0, 0, 0);
      for (int i = 0; i < NODES; i++) send_cmd(OP_DEL_LAST, 0, 0, 0);
      send_cmd(OP_FREE_COUNT, 0, 0, 0);
   endtask

   // hold the receiver off while views pile up behind it
   task automatic test_backpressure();
      for (int i = 0; i < 6; i++) send_cmd(OP_INS_FIRST, 0, $urandom, $urandom);
      rsp_hold = 1'b1;
      fork
         begin
            repeat (300) @(negedge clock);
            rsp_hold = 1'b0;
         end
         for (int i = 0; i < 4; i++) send_cmd(OP_VIEW, 0, 0, 0);
      join
      wait_drained();
   endtask

   task automatic test_random(int items);
      logic [3:0] op;
      for (int i = 0; i < items; i++) begin
         case ($urandom_range(0, 19))
            0:           op = OP_CLEAR;
            1, 2:        op = OP_VIEW;
            3, 4, 5:     op = OP_INS_FIRST;
            6, 7, 8:     op = OP_INS_LAST;
            9, 10:       op = OP_INS_AFTER;
            11:          op = OP_DEL_FIRST;
            12:          op = OP_DEL_LAST;
            13, 14:      op = OP_DEL_KEY;
            15, 16:      op = OP_MODIFY;
            17:          op = OP_FREE_COUNT;
            18:          op = 4'($urandom_range(10, 15));
            default:     op = 4'($urandom_range(0, 9));
         endcase
         send_cmd(op, pick_key(), pick_key(), $urandom);
      end
   endtask

   initial begin
      rebuild_chain();
      for (int i = 0; i < NODES; i++) begin
         key_mem[i] = 0; pay_mem[i] = 0;
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_store();
      test_backpressure();
      test_random(150);
      wait_drained();
      idle_enable = 1'b0;
      test_random(60);
      wait_drained();
      if (errors == 0 && expected_beats.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

`default_nettype wire

### sim.f
rtl/clle_pkg.sv
rtl/clle_datapath.sv
rtl/clle_ctrl.sv
rtl/cursor_linked_list_engine.sv
tb/sv/cursor_linked_list_engine_tb.sv
